// ===== design/tscp_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths and structs of the tangent sphere child position unit.
package tscp_pkg;

  localparam int SqInW  = 68;
  localparam int RootW  = 34;
  localparam int SqRemW = 35;
  localparam int NumW   = 66;
  localparam int DenW   = 35;
  localparam int QuoW   = 34;

  typedef struct packed {
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
    logic signed [31:0] mid_z;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic signed [31:0] half_x;
    logic signed [31:0] half_z;
    logic        [31:0] mag_x;
    logic        [31:0] mag_y;
    logic        [31:0] mag_z;
    logic               neg_x;
    logic               neg_y;
    logic               neg_z;
    logic               far;
    logic               side;
  } tag_t;

  typedef struct packed {
    logic [RootW-1:0] len;
    logic [RootW-1:0] height;
  } roots_t;

  typedef struct packed {
    logic [QuoW-1:0] px;
    logic [QuoW-1:0] pz;
    logic [QuoW-1:0] py;
    logic            den_zero;
  } quots_t;

endpackage

// ===== design/tscp_front.sv =====
`timescale 1ns / 1ps
// Front stages: differences, squares and cross products, far test and side select.
module tscp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [31:0]            first_x,
  input  logic signed [31:0]            first_y,
  input  logic signed [31:0]            first_z,
  input  logic signed [31:0]            second_x,
  input  logic signed [31:0]            second_y,
  input  logic signed [31:0]            second_z,
  input  logic signed [31:0]            normal_x,
  input  logic signed [31:0]            normal_z,
  input  logic [30:0]                   radius,
  output logic                          valid_out,
  output logic [tscp_pkg::SqInW-1:0]    len_op,
  output logic [tscp_pkg::SqInW-1:0]    height_op,
  output tscp_pkg::tag_t                tag_out
);

  logic signed [32:0] dx_w, dy_w, dz_w;
  logic signed [32:0] hx_w, hz_w;
  logic signed [32:0] sx_w, sy_w, sz_w;
  logic signed [32:0] mx_w, my_w, mz_w;
  tscp_pkg::tag_t     tag_a_next;

  logic               va;
  tscp_pkg::tag_t     tag_a;
  logic signed [31:0] alt_x_a, alt_y_a, alt_z_a;
  logic signed [32:0] dx_a, dz_a;
  logic signed [31:0] nx_a, nz_a;

  logic               vb;
  tscp_pkg::tag_t     tag_b;
  logic signed [31:0] alt_x_b, alt_y_b, alt_z_b;
  logic [63:0]        sq_x_b, sq_y_b, sq_z_b;
  logic [61:0]        r2_b;
  logic signed [64:0] cra_b, crb_b;

  logic [65:0]        sum_w, quad_w;
  tscp_pkg::tag_t     tag_c_next;

  logic               vc;
  tscp_pkg::tag_t     tag_c;
  logic [65:0]        sum_c, diff_c;

  always_comb begin
    dx_w = {first_x[31], first_x} - {second_x[31], second_x};
    dy_w = {first_y[31], first_y} - {second_y[31], second_y};
    dz_w = {first_z[31], first_z} - {second_z[31], second_z};
    hx_w = dx_w + {32'd0, dx_w[32]};
    hz_w = dz_w + {32'd0, dz_w[32]};
    sx_w = {first_x[31], first_x} + {second_x[31], second_x};
    sy_w = {first_y[31], first_y} + {second_y[31], second_y};
    sz_w = {first_z[31], first_z} + {second_z[31], second_z};
    mx_w = sx_w + {32'd0, sx_w[32]};
    my_w = sy_w + {32'd0, sy_w[32]};
    mz_w = sz_w + {32'd0, sz_w[32]};
    tag_a_next        = '0;
    tag_a_next.mid_x  = 32'(mx_w >>> 1);
    tag_a_next.mid_y  = 32'(my_w >>> 1);
    tag_a_next.mid_z  = 32'(mz_w >>> 1);
    tag_a_next.base_x = first_x;
    tag_a_next.base_y = first_y;
    tag_a_next.base_z = first_z;
    tag_a_next.half_x = 32'(hx_w >>> 1);
    tag_a_next.half_z = 32'(hz_w >>> 1);
    tag_a_next.mag_x  = 32'(dx_w[32] ? -dx_w : dx_w);
    tag_a_next.mag_y  = 32'(dy_w[32] ? -dy_w : dy_w);
    tag_a_next.mag_z  = 32'(dz_w[32] ? -dz_w : dz_w);
    tag_a_next.neg_x  = dx_w[32];
    tag_a_next.neg_y  = dy_w[32];
    tag_a_next.neg_z  = dz_w[32];
  end

  always_comb begin
    sum_w  = {2'b00, sq_x_b} + {2'b00, sq_y_b} + {2'b00, sq_z_b};
    quad_w = {r2_b, 4'b0000};
    tag_c_next      = tag_b;
    tag_c_next.far  = (quad_w <= sum_w);
    tag_c_next.side = (cra_b < crb_b);
    if (cra_b < crb_b) begin
      tag_c_next.base_x = alt_x_b;
      tag_c_next.base_y = alt_y_b;
      tag_c_next.base_z = alt_z_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
    if (en) begin
      tag_a   <= tag_a_next;
      alt_x_a <= second_x;
      alt_y_a <= second_y;
      alt_z_a <= second_z;
      dx_a    <= dx_w;
      dz_a    <= dz_w;
      nx_a    <= normal_x;
      nz_a    <= normal_z;

      tag_b   <= tag_a;
      alt_x_b <= alt_x_a;
      alt_y_b <= alt_y_a;
      alt_z_b <= alt_z_a;
      sq_x_b  <= tag_a.mag_x * tag_a.mag_x;
      sq_y_b  <= tag_a.mag_y * tag_a.mag_y;
      sq_z_b  <= tag_a.mag_z * tag_a.mag_z;
      r2_b    <= {31'd0, radius} * {31'd0, radius};
      cra_b   <= dz_a * nx_a;
      crb_b   <= dx_a * nz_a;

      tag_c   <= tag_c_next;
      sum_c   <= sum_w;
      diff_c  <= quad_w - sum_w;
    end
  end

  assign valid_out = vc;
  assign len_op    = {2'b00, sum_c};
  assign height_op = {2'b00, diff_c};
  assign tag_out   = tag_c;

endmodule

// ===== design/tscp_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined digit-by-digit square root, two lanes, one result bit per stage.
module tscp_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       valid_in,
  input  logic [tscp_pkg::SqInW-1:0] op_a,
  input  logic [tscp_pkg::SqInW-1:0] op_b,
  input  tscp_pkg::tag_t             tag_in,
  output logic                       valid_out,
  output tscp_pkg::roots_t           roots,
  output tscp_pkg::tag_t             tag_out
);

  localparam int SqInW  = tscp_pkg::SqInW;
  localparam int RootW  = tscp_pkg::RootW;
  localparam int SqRemW = tscp_pkg::SqRemW;

  typedef struct packed {
    logic [SqInW-1:0]  op;
    logic [SqRemW-1:0] rem;
    logic [RootW-1:0]  root;
  } sq_lane_t;

  typedef struct packed {
    sq_lane_t a;
    sq_lane_t b;
  } sq_pair_t;

  function automatic sq_lane_t sq_step(input sq_lane_t cur);
    logic [SqRemW+1:0] rsh;
    logic [SqRemW+1:0] trial;
    sq_lane_t          nxt;
    rsh    = {cur.rem, cur.op[SqInW-1 -: 2]};
    trial  = {1'b0, cur.root, 2'b01};
    nxt.op = {cur.op[SqInW-3:0], 2'b00};
    if (rsh >= trial) begin
      nxt.rem  = SqRemW'(rsh - trial);
      nxt.root = {cur.root[RootW-2:0], 1'b1};
    end else begin
      nxt.rem  = SqRemW'(rsh);
      nxt.root = {cur.root[RootW-2:0], 1'b0};
    end
    return nxt;
  endfunction

  sq_pair_t       pair_q [RootW];
  tscp_pkg::tag_t tag_q  [RootW];
  logic           vld_q  [RootW];
  sq_lane_t       init_a, init_b;

  assign init_a = '{op: op_a, rem: '0, root: '0};
  assign init_b = '{op: op_b, rem: '0, root: '0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= valid_in;
    end
    if (en) begin
      pair_q[0].a <= sq_step(init_a);
      pair_q[0].b <= sq_step(init_b);
      tag_q[0]    <= tag_in;
    end
  end

  for (genvar k = 1; k < RootW; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_q[k-1];
      end
      if (en) begin
        pair_q[k].a <= sq_step(pair_q[k-1].a);
        pair_q[k].b <= sq_step(pair_q[k-1].b);
        tag_q[k]    <= tag_q[k-1];
      end
    end
  end

  assign valid_out    = vld_q[RootW-1];
  assign roots.len    = pair_q[RootW-1].a.root;
  assign roots.height = pair_q[RootW-1].b.root;
  assign tag_out      = tag_q[RootW-1];

endmodule

// ===== design/tscp_div.sv =====
`timescale 1ns / 1ps
// Scaling products and pipelined restoring division, three lanes, one quotient bit per stage.
module tscp_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid_in,
  input  tscp_pkg::roots_t roots,
  input  tscp_pkg::tag_t   tag_in,
  input  logic [30:0]      radius,
  output logic             valid_out,
  output tscp_pkg::quots_t quots,
  output tscp_pkg::tag_t   tag_out
);

  localparam int NumW = tscp_pkg::NumW;
  localparam int DenW = tscp_pkg::DenW;
  localparam int QuoW = tscp_pkg::QuoW;

  typedef struct packed {
    logic [QuoW-1:0] nlo;
    logic [DenW-1:0] rem;
    logic [QuoW-1:0] quo;
    logic [DenW-1:0] den;
  } dv_lane_t;

  typedef struct packed {
    dv_lane_t lx;
    dv_lane_t lz;
    dv_lane_t ly;
  } dv_set_t;

  function automatic dv_lane_t dv_init(input logic [NumW-1:0] num, input logic [DenW-1:0] den);
    dv_lane_t l;
    l.nlo = num[QuoW-1:0];
    l.rem = DenW'(num[NumW-1:QuoW]);
    l.quo = '0;
    l.den = den;
    return l;
  endfunction

  function automatic dv_lane_t dv_step(input dv_lane_t cur);
    logic [DenW:0] rsh;
    logic [DenW:0] dd;
    dv_lane_t      nxt;
    rsh     = {cur.rem, cur.nlo[QuoW-1]};
    dd      = {1'b0, cur.den};
    nxt.nlo = {cur.nlo[QuoW-2:0], 1'b0};
    nxt.den = cur.den;
    if (rsh >= dd) begin
      nxt.rem = DenW'(rsh - dd);
      nxt.quo = {cur.quo[QuoW-2:0], 1'b1};
    end else begin
      nxt.rem = DenW'(rsh);
      nxt.quo = {cur.quo[QuoW-2:0], 1'b0};
    end
    return nxt;
  endfunction

  logic [NumW-1:0] num_x, num_z, num_y;
  logic [DenW-1:0] den_xz, den_y;

  dv_set_t        set_q  [QuoW+1];
  tscp_pkg::tag_t tag_q  [QuoW+1];
  logic           zero_q [QuoW+1];
  logic           vld_q  [QuoW+1];

  always_comb begin
    num_x  = NumW'(tag_in.mag_x) * NumW'(roots.height);
    num_z  = NumW'(tag_in.mag_z) * NumW'(roots.height);
    num_y  = NumW'(tag_in.mag_y) * NumW'({radius, 1'b0});
    den_xz = {roots.len, 1'b0};
    den_y  = {1'b0, roots.len};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= valid_in;
    end
    if (en) begin
      set_q[0].lx <= dv_init(num_x, den_xz);
      set_q[0].lz <= dv_init(num_z, den_xz);
      set_q[0].ly <= dv_init(num_y, den_y);
      zero_q[0]   <= (roots.len == '0);
      tag_q[0]    <= tag_in;
    end
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_q[k-1];
      end
      if (en) begin
        set_q[k].lx <= dv_step(set_q[k-1].lx);
        set_q[k].lz <= dv_step(set_q[k-1].lz);
        set_q[k].ly <= dv_step(set_q[k-1].ly);
        zero_q[k]   <= zero_q[k-1];
        tag_q[k]    <= tag_q[k-1];
      end
    end
  end

  assign valid_out      = vld_q[QuoW];
  assign quots.px       = set_q[QuoW].lx.quo;
  assign quots.pz       = set_q[QuoW].lz.quo;
  assign quots.py       = set_q[QuoW].ly.quo;
  assign quots.den_zero = zero_q[QuoW];
  assign tag_out        = tag_q[QuoW];

endmodule

// ===== design/tangent_sphere_child_position_unit.sv =====
`timescale 1ns / 1ps
// Top level: child sphere center from two tangent parents, Q16.16, fully pipelined.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------------
//  in       | in_valid / in_ready   | first_xyz, second_xyz, normal_x, normal_z
//  out      | out_valid / out_ready | child_x, child_y, child_z, parents_too_far
//  config   | cfg_write             | cfg_data = sphere radius, unsigned Q15.16
//
// One transfer per cycle sustained while out_ready stays high. Path to output:
// 3 front stages, 34 square root stages, 1 product stage, 34 divide stages,
// plus the output buffer, which holds two results.
// rst clears the valid bits and the buffer and sets the radius to 1.0.
// When the buffer is full the whole pipeline holds and in_ready drops.
module tangent_sphere_child_position_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] first_x,
  input  logic signed [31:0] first_y,
  input  logic signed [31:0] first_z,
  input  logic signed [31:0] second_x,
  input  logic signed [31:0] second_y,
  input  logic signed [31:0] second_z,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] child_x,
  output logic signed [31:0] child_y,
  output logic signed [31:0] child_z,
  output logic               parents_too_far
);

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic               far;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -38'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return 32'(v);
    end
  endfunction

  logic [30:0] radius;

  logic                              en;
  logic                              front_valid;
  logic [tscp_pkg::SqInW-1:0]        len_op, height_op;
  tscp_pkg::tag_t                    front_tag;
  logic                              sqrt_valid;
  tscp_pkg::roots_t                  roots;
  tscp_pkg::tag_t                    sqrt_tag;
  logic                              div_valid;
  tscp_pkg::quots_t                  quots;
  tscp_pkg::tag_t                    tag;

  logic signed [35:0] px_mag, pz_mag, py_mag;
  logic signed [35:0] px_s, pz_s, py_s;
  logic signed [35:0] hx, hz, tx, tz;
  logic signed [37:0] bx, by, bz, cx_w, cy_w, cz_w;
  res_t               res;

  res_t       ent [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 31'(1 << FRAC_BITS);
    end else if (cfg_write) begin
      radius <= cfg_data;
    end
  end

  assign en       = (count != 2'd2);
  assign in_ready = en;

  tscp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .first_x   (first_x),
    .first_y   (first_y),
    .first_z   (first_z),
    .second_x  (second_x),
    .second_y  (second_y),
    .second_z  (second_z),
    .normal_x  (normal_x),
    .normal_z  (normal_z),
    .radius    (radius),
    .valid_out (front_valid),
    .len_op    (len_op),
    .height_op (height_op),
    .tag_out   (front_tag)
  );

  tscp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (front_valid),
    .op_a      (len_op),
    .op_b      (height_op),
    .tag_in    (front_tag),
    .valid_out (sqrt_valid),
    .roots     (roots),
    .tag_out   (sqrt_tag)
  );

  tscp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (sqrt_valid),
    .roots     (roots),
    .tag_in    (sqrt_tag),
    .radius    (radius),
    .valid_out (div_valid),
    .quots     (quots),
    .tag_out   (tag)
  );

  always_comb begin
    px_mag = $signed({2'b00, quots.px});
    pz_mag = $signed({2'b00, quots.pz});
    py_mag = $signed({2'b00, quots.py});
    px_s   = quots.den_zero ? 36'sd0 : (tag.neg_x ? -px_mag : px_mag);
    pz_s   = quots.den_zero ? 36'sd0 : (tag.neg_z ? -pz_mag : pz_mag);
    py_s   = quots.den_zero ? 36'sd0 : (tag.neg_y ? -py_mag : py_mag);
    hx     = {{4{tag.half_x[31]}}, tag.half_x};
    hz     = {{4{tag.half_z[31]}}, tag.half_z};
    tx     = hx - pz_s;
    tz     = hz + px_s;
    bx     = {{6{tag.base_x[31]}}, tag.base_x};
    by     = {{6{tag.base_y[31]}}, tag.base_y};
    bz     = {{6{tag.base_z[31]}}, tag.base_z};
    cy_w   = by + {{2{py_s[35]}}, py_s};
    if (tag.side) begin
      cx_w = bx + {{2{tx[35]}}, tx};
      cz_w = bz + {{2{tz[35]}}, tz};
    end else begin
      cx_w = bx - {{2{tx[35]}}, tx};
      cz_w = bz - {{2{tz[35]}}, tz};
    end
    if (tag.far) begin
      res = '{cx: tag.mid_x, cy: tag.mid_y, cz: tag.mid_z, far: 1'b1};
    end else begin
      res = '{cx: sat32(cx_w), cy: sat32(cy_w), cz: sat32(cz_w), far: 1'b0};
    end
  end

  assign push = en && div_valid;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      ent[wr_ptr] <= res;
    end
  end

  assign out_valid       = (count != 2'd0);
  assign child_x         = ent[rd_ptr].cx;
  assign child_y         = ent[rd_ptr].cy;
  assign child_z         = ent[rd_ptr].cz;
  assign parents_too_far = ent[rd_ptr].far;

  a_stall_has_result : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input held while no result is waiting");

  a_resume_after_pop : assert property (@(posedge clk) disable iff (rst)
    $rose(in_ready) |-> $past(out_valid && out_ready))
    else $error("pipeline resumed without an output transfer");

  a_buffer_tracks : assert property (@(posedge clk) disable iff (rst)
    (div_valid && !in_ready && !out_ready) |=> (div_valid && !in_ready))
    else $error("result at pipeline end lost during stall");

endmodule

// ===== test/tb_tangent_sphere_child_position_unit.sv =====
`timescale 1ns / 1ps
// Testbench: random and directed child sphere placements checked against a bit-exact predictor.
module tb_tangent_sphere_child_position_unit;

  localparam int LATENCY = 73;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] p1x, p1y, p1z, p2x, p2y, p2z, nx, nz;
  } pair_t;

  typedef struct {
    logic signed [31:0] cx, cy, cz;
    logic               far;
  } child_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] first_x = '0, first_y = '0, first_z = '0;
  logic signed [31:0] second_x = '0, second_y = '0, second_z = '0;
  logic signed [31:0] normal_x = '0, normal_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] child_x, child_y, child_z;
  logic parents_too_far;

  tangent_sphere_child_position_unit DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .normal_x(normal_x), .normal_z(normal_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .child_x(child_x), .child_y(child_y), .child_z(child_z),
    .parents_too_far(parents_too_far)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  pair_t pending_pairs[$];
  child_t expected_children[$];
  logic [30:0] radius = 31'd65536;
  bit quiet = 1'b0;
  bit gaps_on = 1'b1;
  bit done = 1'b0;
  int n_sent = 0, n_checked = 0, n_far = 0, n_mismatch = 0, n_radii = 0;
  int idle_cycles = 0;

  function automatic logic [33:0] floor_sqrt(input logic [67:0] v);
    logic [33:0] res;
    logic [33:0] t;
    res = '0;
    for (int b = 33; b >= 0; b--) begin
      t = res | (34'd1 << b);
      if ({34'd0, t} * {34'd0, t} <= v) res = t;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] scaled_quot(input logic signed [63:0] v,
                                                     input logic [63:0] m,
                                                     input logic [63:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    mag = v < 0 ? -v : v;
    q = (mag * m) / den;
    return v < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic child_t place_child(input pair_t p, input logic [30:0] r);
    child_t c;
    logic signed [63:0] dx, dy, dz, a, b, px, pz, yo;
    logic [67:0] mgx, mgy, mgz;
    logic [67:0] dist_sq, rad_sq16;
    logic [33:0] len, hgt;
    dx = 64'(p.p1x) - 64'(p.p2x);
    dy = 64'(p.p1y) - 64'(p.p2y);
    dz = 64'(p.p1z) - 64'(p.p2z);
    mgx = 68'(dx < 0 ? -dx : dx);
    mgy = 68'(dy < 0 ? -dy : dy);
    mgz = 68'(dz < 0 ? -dz : dz);
    dist_sq = mgx * mgx + mgy * mgy + mgz * mgz;
    rad_sq16 = 68'({37'd0, r} * {37'd0, r}) << 4;
    if (rad_sq16 <= dist_sq) begin
      c.cx = sat32((64'(p.p1x) + 64'(p.p2x)) / 2);
      c.cy = sat32((64'(p.p1y) + 64'(p.p2y)) / 2);
      c.cz = sat32((64'(p.p1z) + 64'(p.p2z)) / 2);
      c.far = 1'b1;
      return c;
    end
    len = floor_sqrt(dist_sq);
    hgt = floor_sqrt(rad_sq16 - dist_sq);
    a = dx / 2;
    b = dz / 2;
    px = 0; pz = 0; yo = 0;
    if (len != 0) begin
      px = scaled_quot(dx, 64'(hgt), 64'(len) << 1);
      pz = scaled_quot(dz, 64'(hgt), 64'(len) << 1);
      yo = scaled_quot(dy, 64'(r) << 1, 64'(len));
    end
    if (dz * 64'(p.nx) < dx * 64'(p.nz)) begin
      c.cx = sat32(64'(p.p2x) + a - pz);
      c.cy = sat32(64'(p.p2y) + yo);
      c.cz = sat32(64'(p.p2z) + b + px);
    end else begin
      c.cx = sat32(64'(p.p1x) - a + pz);
      c.cy = sat32(64'(p.p1y) + yo);
      c.cz = sat32(64'(p.p1z) - b - px);
    end
    c.far = 1'b0;
    return c;
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh7FFFFFFF - $urandom_range(0, 3);
      2: return 32'sh80000000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
    endcase
  endfunction

  function automatic pair_t near_pair(input logic [30:0] r);
    pair_t p;
    int span;
    span = (r > 31'h1FFFFFFF) ? 32'h7FFFFFFF : int'(r) * 4;
    if (span < 4) span = 4;
    p.p1x = rand_word();
    p.p1y = rand_word();
    p.p1z = rand_word();
    p.p2x = p.p1x + $signed($urandom_range(0, span)) - span / 2;
    p.p2y = p.p1y + $signed($urandom_range(0, span)) - span / 2;
    p.p2z = p.p1z + $signed($urandom_range(0, span)) - span / 2;
    p.nx = $urandom_range(0, 9) == 0 ? 32'sd0 : $signed($urandom);
    p.nz = $urandom_range(0, 9) == 0 ? 32'sd0 : $signed($urandom);
    return p;
  endfunction

  function automatic pair_t any_pair();
    pair_t p;
    p.p1x = rand_word(); p.p1y = rand_word(); p.p1z = rand_word();
    p.p2x = rand_word(); p.p2y = rand_word(); p.p2z = rand_word();
    p.nx = $urandom; p.nz = $urandom;
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        n_sent <= n_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_pairs.size() > 0 && !(gaps_on && $urandom_range(0, 99) < 32)) begin
          pair_t p;
          p = pending_pairs.pop_front();
          expected_children.push_back(place_child(p, radius));
          first_x <= p.p1x; first_y <= p.p1y; first_z <= p.p1z;
          second_x <= p.p2x; second_y <= p.p2y; second_z <= p.p2z;
          normal_x <= p.nx; normal_z <= p.nz;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      out_ready <= !(gaps_on && $urandom_range(0, 99) < 32);
      if (out_valid && out_ready) begin
        if (expected_children.size() == 0) begin
          n_mismatch <= n_mismatch + 1;
          if (n_mismatch < 10) $display("unexpected transfer: %h %h %h %b",
                                        child_x, child_y, child_z, parents_too_far);
        end else begin
          child_t e;
          e = expected_children.pop_front();
          n_checked <= n_checked + 1;
          if (e.far) n_far <= n_far + 1;
          if (e.cx !== child_x || e.cy !== child_y || e.cz !== child_z
              || e.far !== parents_too_far) begin
            n_mismatch <= n_mismatch + 1;
            if (n_mismatch < 10)
              $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                       e.cx, e.cy, e.cz, e.far,
                       child_x, child_y, child_z, parents_too_far);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || quiet) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_children.size() > 0)
      @(posedge clk);
    quiet = 1'b1;
    repeat (LATENCY + 10) @(posedge clk);
    quiet = 1'b0;
  endtask

  task automatic set_radius(input logic [30:0] r);
    drain();
    cfg_data <= r;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    radius = r;
    n_radii++;
  endtask

  initial begin
    pair_t p;
    logic [30:0] radii[6];
    radii = '{31'd1, 31'h7FFFFFFF, 31'd65536, 31'd3, 31'h00100000, 31'h01234567};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed
    p = '{0, 0, 0, 0, 0, 0, 0, 0};
    pending_pairs.push_back(p);
    p = '{32'sh10000, 0, 0, 0, 0, 0, 0, 32'sh10000};
    pending_pairs.push_back(p);
    p = '{32'sh10000, 0, 0, 0, 0, 0, 0, -32'sh10000};
    pending_pairs.push_back(p);
    p = '{32'sh8000, 32'sh4000, 32'sh2000, -32'sh8000, 0, 0, 32'sh10000, 32'sh10000};
    pending_pairs.push_back(p);
    p = '{32'sh40000, 0, 0, 0, 0, 0, 0, 32'sh10000};
    pending_pairs.push_back(p);
    p = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
          32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
    pending_pairs.push_back(p);
    p = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
          32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF};
    pending_pairs.push_back(p);
    p = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh80000000, 0, 0};
    pending_pairs.push_back(p);
    p = '{32'sh7FFF8000, 32'sh7FFF0000, 32'sh7FFF8000, 32'sh7FFF0000, 32'sh7FFF8000,
          32'sh7FFF0000, 32'sh10000, 0};
    pending_pairs.push_back(p);
    p = '{32'sh80008000, 32'sh80000000, 32'sh80010000, 32'sh80000000, 32'sh80010000,
          32'sh80008000, 0, -32'sh10000};
    pending_pairs.push_back(p);
    for (int i = 0; i < 8; i++) pending_pairs.push_back(near_pair(radius));

    // no idling for a stretch
    gaps_on = 1'b0;
    for (int i = 0; i < 150; i++) pending_pairs.push_back(near_pair(radius));
    drain();
    gaps_on = 1'b1;

    for (int k = 0; k < 6; k++) begin
      set_radius(radii[k]);
      for (int i = 0; i < 200; i++)
        pending_pairs.push_back($urandom_range(0, 4) == 0 ? any_pair() : near_pair(radius));
    end
    set_radius(31'd65536);
    for (int i = 0; i < 50; i++) pending_pairs.push_back(near_pair(radius));
    drain();

    $display("checked %0d placements over %0d radius settings, %0d with parents too far",
             n_checked, n_radii, n_far);
    if (n_mismatch == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
